@@ rtl/core/tetji_pkg.sv @@
package tetji_pkg;

   localparam int unsigned COORD_WIDTH_DEF = 32;
   localparam int unsigned FIELD_W         = 32;
   localparam int unsigned N_IN_FIELDS     = 12;
   localparam int unsigned REQ_DATA_W      = N_IN_FIELDS * FIELD_W;
   localparam int unsigned DET_Q_W         = 64;
   localparam int unsigned INV_W           = 32;
   localparam int unsigned N_INV           = 9;
   localparam int unsigned RSP_DATA_W      = 2 * DET_Q_W + N_INV * INV_W;
   localparam int unsigned MIN_DET_W       = 63;
   localparam int unsigned CSR_ADDR_W      = 4;
   localparam int unsigned CSR_DATA_W      = 64;
   localparam int unsigned DIV_STEPS       = INV_W;
   localparam int unsigned VOL_BYTES       = DET_Q_W / 8;
   localparam int unsigned ROUND_SHIFT     = 16;
   localparam int unsigned INV_NUM_SHIFT   = 33;
   localparam int unsigned RECIP6          = 2731;

   localparam logic [0:0] CSR_IDX_MIN_DET = 1'b0;

   // Flat edge indexes (row * 3 + col) of the two products of each cofactor.
   localparam int unsigned COF_TERM [N_INV][4] = '{
      '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
      '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
      '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
   };

   typedef struct packed {
      logic signed [DET_Q_W-1:0] det_q;
      logic [DET_Q_W-1:0]        vol_mag;
      logic [2:0]                vol_rem;
      logic [N_INV-1:0]          neg;
      logic                      degen;
   } tetji_side_type;

   // One byte of a division by six: returns {remainder, quotient byte}.
   function automatic logic [10:0] div6_digit(input logic [10:0] x);
      logic [22:0] prod;
      logic [7:0]  q;
      logic [10:0] r;
      prod = 23'(x) * 23'(RECIP6);
      q    = prod[21:14];
      r    = x - 11'(q) * 11'd6;
      return {r[2:0], q};
   endfunction

endpackage

@@ rtl/core/tetra_element_jacobian_inverse.sv @@
// Throughput: one element per cycle unless rsp_tready stalls the output;
// nine front stages form edges, cofactors, the determinant and the divider
// operands, then 32 stages retire one quotient bit each for all nine inverse
// entries, and one output register follows.
// Reset clears every stage valid bit and sets min_determinant to zero.
module tetra_element_jacobian_inverse import tetji_pkg::*; #(
   parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, v3_x, v3_y, v3_z
   input  logic [REQ_DATA_W-1:0]   req_tdata,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // jac_det, elem_volume, inv_00, inv_01, inv_02, inv_10, inv_11, inv_12,
   // inv_20, inv_21, inv_22
   output logic [RSP_DATA_W-1:0]   rsp_tdata,
   // degenerate
   output logic [0:0]              rsp_tuser,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [CSR_DATA_W-1:0]   csr_pwdata,
   output logic [CSR_DATA_W-1:0]   csr_prdata,
   output logic                    csr_pready
);

   localparam int unsigned E    = COORD_WIDTH + 1;
   localparam int unsigned PW   = 2 * E;
   localparam int unsigned C    = PW + 1;
   localparam int unsigned L    = (C + 1) / 2;
   localparam int unsigned HW   = C - L;
   localparam int unsigned DETW = E + C + 2;
   localparam int unsigned NW   = ((C + INV_NUM_SHIFT > DETW) ? C + INV_NUM_SHIFT : DETW) + 1;
   localparam int unsigned XW   = (DETW + 1 > DET_Q_W + 1) ? DETW + 1 : DET_Q_W + 1;
   localparam int unsigned NF   = 9;

   logic [MIN_DET_W-1:0] min_det_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_det_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr[3] == CSR_IDX_MIN_DET) begin
         min_det_ff <= csr_pwdata[MIN_DET_W-1:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[3] == CSR_IDX_MIN_DET) ?
                       CSR_DATA_W'(min_det_ff) : '0;

   logic [NF-1:0] f_vld_ff;
   logic [NF-1:0] f_rdy;
   logic          ch_valid [DIV_STEPS+1];
   logic          ch_ready [DIV_STEPS+1];

   always_comb begin
      f_rdy[NF-1] = !f_vld_ff[NF-1] || ch_ready[0];
      for (int k = NF - 2; k >= 0; k--) begin
         f_rdy[k] = !f_vld_ff[k] || f_rdy[k+1];
      end
   end

   assign req_tready = f_rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= '0;
      end else begin
         for (int k = 0; k < NF; k++) begin
            if (f_rdy[k]) begin
               f_vld_ff[k] <= (k == 0) ? req_tvalid : f_vld_ff[k-1];
            end
         end
      end
   end

   logic signed [E-1:0]     edge_in [N_INV];
   logic signed [E-1:0]     edge_ff [N_INV];
   logic signed [PW-1:0]    prod_in [2*N_INV];
   logic signed [PW-1:0]    prod_ff [2*N_INV];
   logic signed [E-1:0]     a0_s2_ff [3];
   logic signed [C-1:0]     cof_in [N_INV];
   logic signed [C-1:0]     cof_s3_ff [N_INV];
   logic signed [E-1:0]     a0_s3_ff [3];
   logic signed [E+L:0]     dlo_in [3];
   logic signed [E+L:0]     dlo_ff [3];
   logic signed [E+HW-1:0]  dhi_in [3];
   logic signed [E+HW-1:0]  dhi_ff [3];
   logic signed [C-1:0]     cof_s4_ff [N_INV];
   logic signed [DETW-1:0]  term_in [3];
   logic signed [DETW-1:0]  term_ff [3];
   logic signed [C-1:0]     cof_s5_ff [N_INV];
   logic signed [DETW-1:0]  det_in;
   logic signed [DETW-1:0]  det_s6_ff;
   logic signed [C-1:0]     cof_s6_ff [N_INV];
   logic [DETW-1:0]         absdet_in;
   logic [DETW-1:0]         absdet_ff;
   logic                    detneg_ff;
   logic signed [DETW-1:0]  det_s7_ff;
   logic [C-1:0]            abscof_in [N_INV];
   logic [C-1:0]            abscof_ff [N_INV];
   logic [N_INV-1:0]        cofneg_in;
   logic [N_INV-1:0]        cofneg_ff;
   logic [DETW:0]           rnd_sum;
   logic [XW-1:0]           rnd_mag;
   logic signed [DET_Q_W-1:0] detq_in;
   logic signed [DET_Q_W-1:0] detq_ff;
   logic [NW-1:0]           num_in [N_INV];
   logic [NW-1:0]           num_ff [N_INV];
   logic [NW-1:0]           den_in;
   logic [NW-1:0]           den_ff;
   logic [N_INV-1:0]        cofneg_s8_ff;
   tetji_side_type          side_in;

   logic [NW-1:0]           ch_rem  [DIV_STEPS+1][N_INV];
   logic [INV_W-1:0]        ch_quo  [DIV_STEPS+1][N_INV];
   logic [NW-1:0]           ch_den  [DIV_STEPS+1];
   tetji_side_type          ch_side [DIV_STEPS+1];

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            edge_in[r*3+c] =
               E'($signed(req_tdata[FIELD_W*((c+1)*3+r) +: COORD_WIDTH])) -
               E'($signed(req_tdata[FIELD_W*r +: COORD_WIDTH]));
         end
      end
   end

   always_comb begin
      for (int i = 0; i < N_INV; i++) begin
         prod_in[2*i]   = edge_ff[COF_TERM[i][0]] * edge_ff[COF_TERM[i][1]];
         prod_in[2*i+1] = edge_ff[COF_TERM[i][2]] * edge_ff[COF_TERM[i][3]];
      end
   end

   always_comb begin
      for (int i = 0; i < N_INV; i++) begin
         cof_in[i] = C'(prod_ff[2*i]) - C'(prod_ff[2*i+1]);
      end
   end

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         dlo_in[j] = a0_s3_ff[j] * $signed({1'b0, cof_s3_ff[3*j][L-1:0]});
         dhi_in[j] = a0_s3_ff[j] * $signed(cof_s3_ff[3*j][C-1:L]);
      end
   end

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         term_in[j] = (DETW'(dhi_ff[j]) <<< L) + DETW'(dlo_ff[j]);
      end
   end

   assign det_in = term_ff[0] + term_ff[1] + term_ff[2];

   always_comb begin
      absdet_in = det_s6_ff[DETW-1] ? DETW'(-det_s6_ff) : DETW'(det_s6_ff);
      for (int i = 0; i < N_INV; i++) begin
         cofneg_in[i] = cof_s6_ff[i][C-1];
         abscof_in[i] = cof_s6_ff[i][C-1] ? C'(-cof_s6_ff[i]) : C'(cof_s6_ff[i]);
      end
   end

   always_comb begin
      rnd_sum = (DETW+1)'(absdet_ff) + ((DETW+1)'(1) << (ROUND_SHIFT - 1));
      rnd_mag = XW'(rnd_sum >> ROUND_SHIFT);
      if (detneg_ff) begin
         if (rnd_mag >= XW'(64'h8000_0000_0000_0000)) begin
            detq_in = 64'sh8000_0000_0000_0000;
         end else begin
            detq_in = -$signed(DET_Q_W'(rnd_mag));
         end
      end else begin
         if (rnd_mag > XW'(64'h7FFF_FFFF_FFFF_FFFF)) begin
            detq_in = 64'sh7FFF_FFFF_FFFF_FFFF;
         end else begin
            detq_in = $signed(DET_Q_W'(rnd_mag));
         end
      end
      for (int i = 0; i < N_INV; i++) begin
         num_in[i] = (NW'(abscof_ff[i]) << INV_NUM_SHIFT) + NW'(det_s7_ff);
      end
      den_in = NW'(det_s7_ff) << 1;
   end

   always_comb begin
      side_in.det_q   = detq_ff;
      side_in.vol_mag = detq_ff[DET_Q_W-1] ? DET_Q_W'(-detq_ff) : DET_Q_W'(detq_ff);
      side_in.vol_rem = '0;
      side_in.neg     = cofneg_s8_ff;
      side_in.degen   = detq_ff <= $signed({1'b0, min_det_ff});
   end

   always_ff @(posedge clock) begin
      if (f_rdy[0] && req_tvalid) begin
         edge_ff <= edge_in;
      end
      if (f_rdy[1] && f_vld_ff[0]) begin
         prod_ff  <= prod_in;
         a0_s2_ff <= edge_ff[0:2];
      end
      if (f_rdy[2] && f_vld_ff[1]) begin
         cof_s3_ff <= cof_in;
         a0_s3_ff  <= a0_s2_ff;
      end
      if (f_rdy[3] && f_vld_ff[2]) begin
         dlo_ff    <= dlo_in;
         dhi_ff    <= dhi_in;
         cof_s4_ff <= cof_s3_ff;
      end
      if (f_rdy[4] && f_vld_ff[3]) begin
         term_ff   <= term_in;
         cof_s5_ff <= cof_s4_ff;
      end
      if (f_rdy[5] && f_vld_ff[4]) begin
         det_s6_ff <= det_in;
         cof_s6_ff <= cof_s5_ff;
      end
      if (f_rdy[6] && f_vld_ff[5]) begin
         absdet_ff <= absdet_in;
         detneg_ff <= det_s6_ff[DETW-1];
         det_s7_ff <= det_s6_ff;
         abscof_ff <= abscof_in;
         cofneg_ff <= cofneg_in;
      end
      if (f_rdy[7] && f_vld_ff[6]) begin
         detq_ff      <= detq_in;
         num_ff       <= num_in;
         den_ff       <= den_in;
         cofneg_s8_ff <= cofneg_ff;
      end
      if (f_rdy[8] && f_vld_ff[7]) begin
         ch_side[0] <= side_in;
         ch_rem[0]  <= num_ff;
         ch_den[0]  <= den_ff;
      end
   end

   assign ch_valid[0] = f_vld_ff[NF-1];

   always_comb begin
      for (int i = 0; i < N_INV; i++) begin
         ch_quo[0][i] = '0;
      end
   end

   for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
      tetji_div_step #(
         .NW    (NW),
         .SHIFT (DIV_STEPS - 1 - g),
         .VBYTE (g)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (ch_valid[g]),
         .in_ready  (ch_ready[g]),
         .in_rem    (ch_rem[g]),
         .in_quo    (ch_quo[g]),
         .in_den    (ch_den[g]),
         .in_side   (ch_side[g]),
         .out_valid (ch_valid[g+1]),
         .out_ready (ch_ready[g+1]),
         .out_rem   (ch_rem[g+1]),
         .out_quo   (ch_quo[g+1]),
         .out_den   (ch_den[g+1]),
         .out_side  (ch_side[g+1])
      );
   end

   logic                  rsp_vld_ff;
   logic [RSP_DATA_W-1:0] rsp_data_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [0:0]            rsp_user_ff;
   logic [INV_W-1:0]      quo_fin;
   tetji_side_type        side_fin;

   assign ch_ready[DIV_STEPS] = !rsp_vld_ff || rsp_tready;
   assign side_fin            = ch_side[DIV_STEPS];

   always_comb begin
      rsp_data_in[DET_Q_W-1:0] = side_fin.det_q;
      rsp_data_in[2*DET_Q_W-1:DET_Q_W] = side_fin.det_q[DET_Q_W-1] ?
                                         -side_fin.vol_mag : side_fin.vol_mag;
      for (int i = 0; i < N_INV; i++) begin
         quo_fin = ch_quo[DIV_STEPS][i];
         if (side_fin.degen) begin
            rsp_data_in[2*DET_Q_W + INV_W*i +: INV_W] = '0;
         end else if (side_fin.neg[i]) begin
            rsp_data_in[2*DET_Q_W + INV_W*i +: INV_W] =
               quo_fin[INV_W-1] ? 32'h8000_0000 : -quo_fin;
         end else begin
            rsp_data_in[2*DET_Q_W + INV_W*i +: INV_W] =
               quo_fin[INV_W-1] ? 32'h7FFF_FFFF : quo_fin;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (ch_ready[DIV_STEPS]) begin
         rsp_vld_ff <= ch_valid[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (ch_ready[DIV_STEPS] && ch_valid[DIV_STEPS]) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= side_fin.degen;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

@@ rtl/core/tetji_div_step.sv @@
module tetji_div_step import tetji_pkg::*; #(
   parameter int unsigned NW    = 103,
   parameter int unsigned SHIFT = 0,
   parameter int unsigned VBYTE = VOL_BYTES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [NW-1:0]        in_rem [N_INV],
   input  logic [INV_W-1:0]     in_quo [N_INV],
   input  logic [NW-1:0]        in_den,
   input  tetji_side_type       in_side,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [NW-1:0]        out_rem [N_INV],
   output logic [INV_W-1:0]     out_quo [N_INV],
   output logic [NW-1:0]        out_den,
   output tetji_side_type       out_side
);

   localparam int unsigned CW2 = NW + SHIFT;
   localparam int unsigned BLO = (VBYTE < VOL_BYTES) ? 8 * (VOL_BYTES - 1 - VBYTE) : 0;

   logic                valid_ff;
   logic [NW-1:0]       rem_in [N_INV];
   logic [NW-1:0]       rem_ff [N_INV];
   logic [INV_W-1:0]    quo_in [N_INV];
   logic [INV_W-1:0]    quo_ff [N_INV];
   logic [NW-1:0]       den_ff;
   tetji_side_type      side_in;
   tetji_side_type      side_ff;
   logic [CW2-1:0]      den_sh;
   logic [10:0]         digit;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_quo   = quo_ff;
   assign out_den   = den_ff;
   assign out_side  = side_ff;

   always_comb begin
      den_sh = CW2'(in_den) << SHIFT;
      for (int i = 0; i < N_INV; i++) begin
         if (CW2'(in_rem[i]) >= den_sh) begin
            rem_in[i] = NW'(CW2'(in_rem[i]) - den_sh);
            quo_in[i] = in_quo[i] | (INV_W'(1) << SHIFT);
         end else begin
            rem_in[i] = in_rem[i];
            quo_in[i] = in_quo[i];
         end
      end
   end

   always_comb begin
      side_in = in_side;
      digit   = div6_digit({in_side.vol_rem, in_side.vol_mag[BLO +: 8]});
      if (VBYTE < VOL_BYTES) begin
         side_in.vol_mag[BLO +: 8] = digit[7:0];
         side_in.vol_rem           = digit[10:8];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         den_ff  <= in_den;
         side_ff <= side_in;
      end
   end

endmodule

@@ rtl/core/tetji_checker.sv @@
module tetji_checker import tetji_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [0:0]            rsp_tuser
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("Result valid right after reset.");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("Stalled result changed or dropped.");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[RSP_DATA_W-1:2*DET_Q_W] == '0)
      else $error("Degenerate element with nonzero inverse.");

   a_neg_degen: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[DET_Q_W-1] |-> rsp_tuser[0])
      else $error("Negative determinant not flagged degenerate.");

endmodule

bind tetra_element_jacobian_inverse tetji_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
